### rtl/hlva_pkg.sv
// Shared types, constants and defaults for the Hough line vote accumulator.
package hlva_pkg;

  localparam int DEF_MAX_THETA  = 256;
  localparam int DEF_MAX_RHO    = 1024;
  localparam int DEF_COORD_BITS = 10;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [10:0] RST_IMAGE_ROWS  = 11'd512;
  localparam logic [8:0]  RST_THETA_COUNT = 9'd180;
  localparam logic [10:0] RST_RHO_COUNT   = 11'd724;
  localparam logic [15:0] RST_RHO_SCALE   = 16'd256;

  localparam int COL_W      = 11;
  localparam int DY_W       = 12;
  localparam int TRIG_W     = 16;
  localparam int P_COS_W    = 27;
  localparam int P_SIN_W    = 28;
  localparam int SUM_W      = 29;
  localparam int RHO_MAG_W  = 28;
  localparam int SCALED_W   = 44;
  localparam int FRAC_SHIFT = 22;
  localparam int BIN_W      = SCALED_W - FRAC_SHIFT;
  localparam int OUT_W      = 16;

  typedef enum logic [1:0] {
    OP_VOTE = 2'd0,
    OP_READ = 2'd1,
    OP_LOAD = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic [10:0] image_rows;
    logic [8:0]  theta_count;
    logic [10:0] rho_count;
    logic [15:0] rho_scale;
  } cfg_t;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic load_trig;
    logic theta_issue;
    logic read_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_vote;
    logic in_read;
    logic in_load;
    logic tn_zero;
    logic theta_last;
    logic clear_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

### rtl/hlva_regs.sv
// Configuration register file with its APB-style access port.
module hlva_regs
  import hlva_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_THETA_COUNT = 2'd1,
    REG_RHO_COUNT   = 2'd2,
    REG_RHO_SCALE   = 2'd3
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows  <= RST_IMAGE_ROWS;
      cfg.theta_count <= RST_THETA_COUNT;
      cfg.rho_count   <= RST_RHO_COUNT;
      cfg.rho_scale   <= RST_RHO_SCALE;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_ROWS:  cfg.image_rows  <= pwdata[10:0];
        REG_THETA_COUNT: cfg.theta_count <= pwdata[8:0];
        REG_RHO_COUNT:   cfg.rho_count   <= pwdata[10:0];
        REG_RHO_SCALE:   cfg.rho_scale   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_ROWS:  prdata = CFG_DW'(cfg.image_rows);
      REG_THETA_COUNT: prdata = CFG_DW'(cfg.theta_count);
      REG_RHO_COUNT:   prdata = CFG_DW'(cfg.rho_count);
      REG_RHO_SCALE:   prdata = CFG_DW'(cfg.rho_scale);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/hlva_ctrl.sv
// Controller state machine sequencing clear, vote, read and table load transactions.
module hlva_ctrl
  import hlva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = sts.in_vote || sts.in_read;
          cmd.load_trig = sts.in_load;
        end
      end
      ST_VOTE:      cmd.theta_issue = 1'b1;
      ST_READ:      cmd.read_issue  = 1'b1;
      ST_READ_WAIT: cmd.out_load    = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (sts.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (sts.in_vote && !sts.tn_zero) state <= ST_VOTE;
            else if (sts.in_read)            state <= ST_READ;
          end
        end
        ST_VOTE: begin
          if (sts.theta_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (sts.pipe_empty) state <= ST_IDLE;
        end
        ST_READ: state <= ST_READ_WAIT;
        ST_READ_WAIT: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/hlva_datapath.sv
// Datapath: trig table, rho pipeline, vote memory and output register.
module hlva_datapath
  import hlva_pkg::*;
#(
  parameter int MAX_THETA  = DEF_MAX_THETA,
  parameter int MAX_RHO    = DEF_MAX_RHO,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  cfg_t              cfg,
  input  logic [1:0]        op,
  input  logic [9:0]        pixel_row,
  input  logic [9:0]        pixel_col,
  input  logic [7:0]        outline_value,
  input  logic [7:0]        theta_index,
  input  logic [9:0]        rho_index,
  input  logic [15:0]       cos_entry,
  input  logic [15:0]       sin_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_count
);

  localparam int TW     = $clog2(MAX_THETA);
  localparam int RW     = $clog2(MAX_RHO);
  localparam int VAW    = TW + RW;
  localparam int VDEPTH = MAX_THETA * (2 ** RW);
  localparam logic [9:0] COORD_MASK = 10'((64'd1 << COORD_BITS) - 64'd1);

  // Item registers.
  logic signed [COL_W-1:0] col_q;
  logic signed [DY_W-1:0]  dy_q;
  logic [7:0]              ti_q;
  logic [9:0]              ri_q;
  logic [9:0]              row_m;
  logic [9:0]              col_m;

  // Counters.
  logic [TW-1:0]  theta;
  logic [VAW-1:0] clr_addr;

  // Limits.
  logic [31:0] tn32;
  logic [31:0] rlim32;
  logic [31:0] ti_in32;
  logic [31:0] ti_q32;
  logic [31:0] ri_q32;

  // Memories.
  logic [2*TRIG_W-1:0]   trig_mem [MAX_THETA];
  logic [COUNT_BITS-1:0] vote_mem [VDEPTH];
  logic [2*TRIG_W-1:0]   trig_q;
  logic [COUNT_BITS-1:0] rd_data;

  // Pipeline.
  logic [4:0]                pipe_v;
  logic [TW-1:0]             t1, t2, t3, t4;
  logic [VAW-1:0]            a5;
  logic signed [TRIG_W-1:0]  cos1, sin1;
  logic signed [P_COS_W-1:0] p_cos;
  logic signed [P_SIN_W-1:0] p_sin;
  logic signed [P_COS_W-1:0] p_cos_d;
  logic signed [P_SIN_W-1:0] p_sin_d;
  logic signed [SUM_W-1:0]   rho;
  logic [RHO_MAG_W-1:0]      rho_mag;
  logic [SCALED_W-1:0]       scaled_d;
  logic [SCALED_W-1:0]       scaled;
  logic                      pos4;
  logic [BIN_W-1:0]          bin;
  logic                      bin_ok;

  // Memory port.
  logic                  re, we;
  logic [VAW-1:0]        raddr, waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic                  rd_ok;
  logic [31:0]           rd32;
  logic [OUT_W-1:0]      sat;

  assign row_m   = pixel_row & COORD_MASK;
  assign col_m   = pixel_col & COORD_MASK;
  assign tn32    = (32'(cfg.theta_count) < 32'(MAX_THETA)) ? 32'(cfg.theta_count)
                                                           : 32'(MAX_THETA);
  assign rlim32  = (32'(cfg.rho_count) < 32'(MAX_RHO)) ? 32'(cfg.rho_count) : 32'(MAX_RHO);
  assign ti_in32 = 32'(theta_index);
  assign ti_q32  = 32'(ti_q);
  assign ri_q32  = 32'(ri_q);

  assign sts.in_vote    = (op_t'(op) == OP_VOTE) && (outline_value != 8'd1);
  assign sts.in_read    = (op_t'(op) == OP_READ);
  assign sts.in_load    = (op_t'(op) == OP_LOAD);
  assign sts.tn_zero    = (tn32 == 32'd0);
  assign sts.theta_last = (32'(theta) == tn32 - 32'd1);
  assign sts.clear_last = (32'(clr_addr) == 32'(VDEPTH - 1));
  assign sts.pipe_empty = (pipe_v == '0);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_q <= $signed({1'b0, col_m});
      dy_q  <= $signed({1'b0, cfg.image_rows}) - $signed({2'b00, row_m});
      ti_q  <= theta_index;
      ri_q  <= rho_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      theta    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.load_item)        theta <= '0;
      else if (cmd.theta_issue) theta <= theta + 1'b1;
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_trig && (ti_in32 < 32'(MAX_THETA))) begin
      trig_mem[ti_in32[TW-1:0]] <= {sin_entry, cos_entry};
    end
    if (cmd.theta_issue) begin
      trig_q <= trig_mem[theta];
    end
  end

  assign cos1     = $signed(trig_q[TRIG_W-1:0]);
  assign sin1     = $signed(trig_q[2*TRIG_W-1:TRIG_W]);
  assign p_cos_d  = col_q * cos1;
  assign p_sin_d  = dy_q * sin1;
  assign rho_mag  = rho[RHO_MAG_W-1:0];
  assign scaled_d = rho_mag * cfg.rho_scale;
  assign bin      = scaled[SCALED_W-1:FRAC_SHIFT];
  assign bin_ok   = pos4 && (bin != '0) && (32'(bin) < rlim32);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else begin
      pipe_v <= {pipe_v[3] && bin_ok, pipe_v[2:0], cmd.theta_issue};
    end
  end

  always_ff @(posedge clk) begin
    t1     <= theta;
    t2     <= t1;
    t3     <= t2;
    t4     <= t3;
    p_cos  <= p_cos_d;
    p_sin  <= p_sin_d;
    rho    <= SUM_W'(p_cos) + SUM_W'(p_sin);
    scaled <= scaled_d;
    pos4   <= (rho > 0);
    a5     <= {t4, bin[RW-1:0]};
  end

  assign re    = cmd.read_issue || (pipe_v[3] && bin_ok);
  assign raddr = cmd.read_issue ? {ti_q32[TW-1:0], ri_q32[RW-1:0]} : {t4, bin[RW-1:0]};
  assign we    = cmd.clear_step || pipe_v[4];
  assign waddr = cmd.clear_step ? clr_addr : a5;
  assign wdata = cmd.clear_step ? '0 : ((rd_data == '1) ? rd_data : rd_data + 1'b1);

  always_ff @(posedge clk) begin
    if (we) begin
      vote_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= vote_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_ok <= (ti_q32 < 32'(MAX_THETA)) && (ri_q32 < 32'(MAX_RHO));
    end
  end

  assign rd32 = 32'(rd_data);
  assign sat  = (rd32 > 32'h0000_FFFF) ? '1 : rd32[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count <= rd_ok ? sat : '0;
    end
  end

endmodule

### rtl/hough_line_vote_accumulator.sv
// Top level of the Hough line vote accumulator.
// Usage:
// The input stream carries one command per transaction, selected by s_tuser:
// vote for a pixel, read one accumulator bin, or load one cos/sin table entry.
// Only a read produces an output transaction, carrying the bin count on m_tdata.
// Configuration registers (image rows, theta count, rho count, rho scale) are
// written through the APB-style port; the user is bound to write them only
// while the block is idle, and the block itself does not enforce this.
// Throughput: a vote on an edge pixel issues one theta bin per cycle, then
// drains the rho pipeline and the vote read-modify-write before the next
// transaction is accepted. A read passes the read and read-wait states to
// its output register. The single write port of the vote memory sets the
// one-bin-per-cycle rate. After reset the vote memory is swept clear one
// entry per cycle, MAX_THETA * 2**clog2(MAX_RHO) entries (262144 by default);
// s_tready stays low. Configuration writes are taken during that sweep.
// The result waits in an output register while m_tready is low; further
// vote and load transactions are accepted, and a new read waits for it to drain.
module hough_line_vote_accumulator
  import hlva_pkg::*;
#(
  parameter int MAX_THETA  = DEF_MAX_THETA,
  parameter int MAX_RHO    = DEF_MAX_RHO,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // row[9:0], col[19:10], outline_value[27:20], theta_index[35:28],
  // rho_index[45:36], cos_entry[61:46], sin_entry[77:62], zero pad[79:78]
  input  logic [79:0]       s_tdata,
  // op[1:0]
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // bin_count[15:0]
  output logic [15:0]       m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  hlva_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlva_datapath #(
    .MAX_THETA  (MAX_THETA),
    .MAX_RHO    (MAX_RHO),
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .op            (s_tuser),
    .pixel_row     (s_tdata[9:0]),
    .pixel_col     (s_tdata[19:10]),
    .outline_value (s_tdata[27:20]),
    .theta_index   (s_tdata[35:28]),
    .rho_index     (s_tdata[45:36]),
    .cos_entry     (s_tdata[61:46]),
    .sin_entry     (s_tdata[77:62]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_count     (m_tdata)
  );

endmodule

### rtl/hlva_checker.sv
// Port-level assertions for the Hough line vote accumulator, with their bind.
module hlva_checker
  import hlva_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic rd_accept;

  assign rd_accept = s_tvalid && s_tready && (op_t'(s_tuser) == OP_READ);

  // The clearing sweep blocks input right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during the clearing sweep");

  // A read transaction holds off further input while it completes.
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    rd_accept |=> !s_tready)
    else $error("input ready directly after a read transaction");

  // With the output register empty, a read result appears once the read has passed the read and read-wait states.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    rd_accept && !m_tvalid |-> ##3 m_tvalid)
    else $error("read result missing after three cycles");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transaction changed");

endmodule

bind hough_line_vote_accumulator hlva_checker u_hlva_checker (.*);

### bench/hlva_tb_pkg.sv
`timescale 1ns / 100ps
// Command layout, register map and the vote tally checker for the accumulator bench.
package hlva_tb_pkg;
  import hlva_pkg::*;

  typedef enum int {
    REG_IMAGE_ROWS  = 0,
    REG_THETA_COUNT = 1,
    REG_RHO_COUNT   = 2,
    REG_RHO_SCALE   = 3
  } reg_idx_t;

  // Same packing as s_tdata, last field (pixel_row) in the lowest bits.
  typedef struct packed {
    logic [1:0]         pad;
    logic signed [15:0] sin_entry;
    logic signed [15:0] cos_entry;
    logic [9:0]         rho_index;
    logic [7:0]         theta_index;
    logic [7:0]         outline_value;
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
  } hough_cmd_t;

  typedef struct {
    logic [15:0] count;
    int          theta;
    int          rho;
  } bin_read_t;

  class vote_tally_checker;
    bit [15:0]   tally_store [DEF_MAX_THETA * DEF_MAX_RHO];
    shortint     cos_tab [DEF_MAX_THETA];
    shortint     sin_tab [DEF_MAX_THETA];
    bit [10:0]   image_rows  = RST_IMAGE_ROWS;
    bit [8:0]    theta_count = RST_THETA_COUNT;
    bit [10:0]   rho_count   = RST_RHO_COUNT;
    bit [15:0]   rho_scale   = RST_RHO_SCALE;
    bin_read_t   counts_due[$];
    int          hot_bins[$];
    int          mismatches = 0;

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_IMAGE_ROWS:  image_rows  = value[10:0];
        REG_THETA_COUNT: theta_count = value[8:0];
        REG_RHO_COUNT:   rho_count   = value[10:0];
        REG_RHO_SCALE:   rho_scale   = value[15:0];
        default: ;
      endcase
    endfunction

    function void cast_votes(bit [9:0] row, bit [9:0] col);
      longint dy;
      longint rho;
      longint bin;
      int     tn;
      int     rlim;
      int     idx;
      tn   = (theta_count < DEF_MAX_THETA) ? int'(theta_count) : DEF_MAX_THETA;
      rlim = (rho_count < DEF_MAX_RHO) ? int'(rho_count) : DEF_MAX_RHO;
      dy   = longint'(image_rows) - longint'(row);
      for (int t = 0; t < tn; t++) begin
        rho = longint'(col) * longint'(cos_tab[t]) + dy * longint'(sin_tab[t]);
        if (rho > 0) begin
          bin = (rho * longint'(rho_scale)) >> FRAC_SHIFT;
          if (bin != 0 && bin < rlim) begin
            idx = t * DEF_MAX_RHO + int'(bin);
            if (tally_store[idx] != 16'hFFFF) tally_store[idx]++;
            hot_bins.push_back(idx);
            if (hot_bins.size() > 256) void'(hot_bins.pop_front());
          end
        end
      end
    endfunction

    function void take_command(op_t op, hough_cmd_t c);
      bin_read_t r;
      case (op)
        OP_VOTE: begin
          if (c.outline_value != 8'd1) cast_votes(c.pixel_row, c.pixel_col);
        end
        OP_READ: begin
          r.theta = c.theta_index;
          r.rho   = c.rho_index;
          r.count = tally_store[r.theta * DEF_MAX_RHO + r.rho];
          counts_due.push_back(r);
        end
        OP_LOAD: begin
          cos_tab[c.theta_index] = c.cos_entry;
          sin_tab[c.theta_index] = c.sin_entry;
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_count(logic [15:0] actual);
      bin_read_t r;
      if (counts_due.size() == 0) begin
        report($sformatf("bin_count %0d arrived with no read outstanding", actual));
      end else begin
        r = counts_due.pop_front();
        if (actual !== r.count)
          report($sformatf("bin_count mismatch at theta %0d rho %0d: expected %0d, actual %0d",
                           r.theta, r.rho, r.count, actual));
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction

    function bit pick_hot(output int theta, output int rho);
      int idx;
      if (hot_bins.size() == 0) return 1'b0;
      idx   = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
      theta = idx / DEF_MAX_RHO;
      rho   = idx % DEF_MAX_RHO;
      return 1'b1;
    endfunction
  endclass

endpackage

### bench/hough_line_vote_accumulator_tb.sv
`timescale 1ns / 100ps
// Testbench top that drives votes, bin reads and table loads and checks every bin count.
module hough_line_vote_accumulator_tb;
  import hlva_pkg::*;
  import hlva_tb_pkg::*;

  localparam int SETTLE_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [79:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  vote_tally_checker tally;
  bit tx_on = 1'b0;
  int burst_left = 0;
  int stall_mode = 0;
  int cyc = 0;

  always #1 clk = ~clk;

  hough_line_vote_accumulator uut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tally.check_count(m_tdata);
      if (s_tvalid && s_tready) tally.take_command(op_t'(s_tuser), hough_cmd_t'(s_tdata));
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 400 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((cyc % 9) < 5);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tally.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(op_t op, hough_cmd_t c);
    int gap;
    s_tuser  <= op;
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    tx_on = 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        tx_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops the input stream and waits for every outstanding read to return.
  task automatic drain(int extra);
    if (tx_on) begin
      s_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    while (tally.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic hough_cmd_t rand_cmd();
    hough_cmd_t c;
    c.pad           = '0;
    c.pixel_row     = $urandom;
    c.pixel_col     = $urandom;
    c.outline_value = $urandom;
    c.theta_index   = $urandom;
    c.rho_index     = $urandom;
    c.cos_entry     = 16'(int'($urandom_range(0, 32768)) - 16384);
    c.sin_entry     = 16'(int'($urandom_range(0, 32768)) - 16384);
    return c;
  endfunction

  task automatic issue(op_t op, int row, int col, int outline, int theta, int rho,
                       int cs, int sn);
    hough_cmd_t c;
    c.pad           = '0;
    c.pixel_row     = 10'(row);
    c.pixel_col     = 10'(col);
    c.outline_value = 8'(outline);
    c.theta_index   = 8'(theta);
    c.rho_index     = 10'(rho);
    c.cos_entry     = 16'(cs);
    c.sin_entry     = 16'(sn);
    send(op, c);
  endtask

  task automatic read_hot();
    int th;
    int rh;
    if (tally.pick_hot(th, rh)) issue(OP_READ, 0, 0, 0, th, rh, 0, 0);
  endtask

  task automatic load_trig(int tn);
    hough_cmd_t c;
    real ang;
    for (int t = 0; t < tn; t++) begin
      c = rand_cmd();
      ang = 3.14159 * t / tn;
      c.theta_index = 8'(t);
      c.cos_entry   = 16'(int'(16384.0 * $cos(ang)));
      c.sin_entry   = 16'(int'(16384.0 * $sin(ang)));
      send(OP_LOAD, c);
    end
  endtask

  task automatic rand_item(output op_t op, output hough_cmd_t c);
    int r;
    int th;
    int rh;
    real ang;
    c = rand_cmd();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      op = OP_VOTE;
      if ($urandom_range(0, 9) == 0) c.outline_value = 8'd1;
    end else if (r < 80) begin
      op = OP_READ;
      if ($urandom_range(0, 2) != 0 && tally.pick_hot(th, rh)) begin
        c.theta_index = 8'(th);
        c.rho_index   = 10'(rh);
      end
    end else if (r < 95) begin
      op = OP_LOAD;
      if ($urandom_range(0, 1) == 1) begin
        ang = 3.14159 * $urandom_range(0, 999) / 1000.0;
        c.cos_entry = 16'(int'(16384.0 * $cos(ang)));
        c.sin_entry = 16'(int'(16384.0 * $sin(ang)));
      end
    end else begin
      op = OP_NONE;
    end
  endtask

  task automatic run_phase(int rows, int thetas, int rhos, int scale, int n_items);
    op_t        op;
    hough_cmd_t c;
    drain(SETTLE_CYCLES);
    reg_write(REG_IMAGE_ROWS, rows);
    reg_write(REG_THETA_COUNT, thetas);
    reg_write(REG_RHO_COUNT, rhos);
    reg_write(REG_RHO_SCALE, scale);
    load_trig((thetas < DEF_MAX_THETA) ? thetas : DEF_MAX_THETA);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain(0);
      rand_item(op, c);
      send(op, c);
    end
  endtask

  initial begin
    tally = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Registers are taken while the vote store is still being cleared.
    reg_write(REG_IMAGE_ROWS, 600);
    reg_write(REG_THETA_COUNT, 8);
    reg_write(REG_RHO_COUNT, 1024);
    reg_write(REG_RHO_SCALE, 256);
    load_trig(DEF_MAX_THETA);

    issue(OP_VOTE, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_VOTE, 1023, 1023, 255, 0, 0, 0, 0);
    issue(OP_VOTE, 300, 500, 1, 0, 0, 0, 0);
    issue(OP_VOTE, 300, 500, 2, 0, 0, 0, 0);
    issue(OP_VOTE, 300, 500, 2, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 1023, 1023, 255, 255, 1023, 0, 0);
    read_hot();
    read_hot();
    read_hot();
    issue(OP_LOAD, 0, 0, 0, 255, 0, -16384, 16384);
    issue(OP_LOAD, 0, 0, 0, 0, 0, 16384, -16384);
    issue(OP_VOTE, 599, 1023, 128, 0, 0, 0, 0);
    read_hot();
    issue(OP_NONE, 1023, 1023, 255, 255, 1023, -1, -1);
    issue(OP_NONE, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 1, 0, 0);

    run_phase(1, 1, 1, 1, 60);
    run_phase(1024, 256, 1024, 65535, 80);
    run_phase(1024, 32, 1024, 256, 70);
    for (int p = 0; p < 7; p++)
      run_phase($urandom_range(1, 1024), $urandom_range(2, 48),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                            : $urandom_range(256, 1024),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                            : $urandom_range(128, 512),
                70);

    drain(SETTLE_CYCLES);
    if (tally.mismatches == 0 && tally.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
